// ----- hw/rtl/lkoc_pkg.sv -----
// Package for the keyed object cache core: sizes, operation codes and the
// structs passed between the controller and the datapath. No dependencies.
package lkoc_pkg;

    localparam int unsigned ENTRIES      = 16;
    localparam int unsigned IDX_W        = $clog2(ENTRIES);
    localparam int unsigned CNT_W        = IDX_W + 1;
    localparam int unsigned KEY_W        = 64;
    localparam int unsigned KEY_BITS_DEF = 64;
    localparam int unsigned FUNC_W       = 2;
    localparam int unsigned CAP_RESET    = 16;
    localparam int unsigned RES_W        = 24;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP  = 2'd0,
        FUNC_GET     = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_RSVD    = 2'd3
    } t_func;

    // Result beat, lowest field in the lowest bits.
    typedef struct packed {
        logic [1:0]       pad;
        logic [CNT_W-1:0] occupancy;
        logic [CNT_W-1:0] evicted_in_use;
        logic [CNT_W-1:0] evicted_count;
        logic [IDX_W-1:0] slot;
        logic             created;
        logic             live_hit;
        logic             present;
    } t_res;

    typedef struct packed {
        logic load_in;
        logic apply;
        logic clr_ev;
        logic evict;
        logic insert;
    } t_cmd;

    typedef struct packed {
        logic miss_create;
        logic need_evict;
        logic over_limit;
    } t_stat;

endpackage

// ----- hw/rtl/lkoc_dpath.sv -----
// Datapath of the keyed object cache: key store, match logic, recency ranks,
// eviction and insertion, configuration and result registers. Uses lkoc_pkg.
module lkoc_dpath #(
    parameter int unsigned KEY_BITS = lkoc_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lkoc_pkg::t_cmd                i_cmd,
    output lkoc_pkg::t_stat               o_stat,
    input  logic [lkoc_pkg::FUNC_W-1:0]   i_func,
    input  logic [lkoc_pkg::KEY_W-1:0]    i_key,
    input  logic                          i_cfg_we,
    input  logic [lkoc_pkg::CNT_W-1:0]    i_cfg_wdata,
    output lkoc_pkg::t_res                o_res
);

    localparam int unsigned N  = lkoc_pkg::ENTRIES;
    localparam int unsigned IW = lkoc_pkg::IDX_W;
    localparam int unsigned CW = lkoc_pkg::CNT_W;

    lkoc_pkg::t_func    r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_keys [N];
    logic [N-1:0]       r_valid;
    logic [N-1:0]       r_live;
    logic [IW-1:0]      r_rank [N];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_limit;
    logic [CW-1:0]      r_ev_cnt;
    logic [CW-1:0]      r_ev_live;
    lkoc_pkg::t_res     r_res;

    logic [N-1:0]  w_match;
    logic [N-1:0]  w_victim;
    logic          w_hit;
    logic [IW-1:0] w_hit_slot;
    logic [IW-1:0] w_hit_rank;
    logic          w_hit_live;
    logic          w_victim_live;
    logic [IW-1:0] w_free_slot;
    logic [CW-1:0] w_lim;
    logic [CW-1:0] w_cnt_m1;
    logic          w_promote;

    assign w_lim = (r_limit == '0) ? CW'(1)
                 : (r_limit > CW'(N)) ? CW'(N) : r_limit;
    assign w_cnt_m1 = r_count - CW'(1);

    always_comb begin
        w_hit_slot = '0;
        w_hit_rank = '0;
        w_hit_live = 1'b0;
        w_free_slot = '0;
        for (int i = 0; i < N; i++) begin
            w_match[i]  = r_valid[i] && (r_keys[i] == r_key);
            w_victim[i] = r_valid[i] && (r_rank[i] == w_cnt_m1[IW-1:0]);
            if (w_match[i]) begin
                w_hit_slot = w_hit_slot | IW'(i);
                w_hit_rank = w_hit_rank | r_rank[i];
                w_hit_live = w_hit_live | r_live[i];
            end
        end
        // Lowest-index free entry wins.
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_slot = IW'(i);
            end
        end
    end

    assign w_hit         = |w_match;
    assign w_victim_live = |(w_victim & r_live);
    assign w_promote     = w_hit && (r_func == lkoc_pkg::FUNC_LOOKUP
                                     || r_func == lkoc_pkg::FUNC_GET);

    assign o_stat.miss_create = (r_func == lkoc_pkg::FUNC_GET) && !w_hit;
    assign o_stat.need_evict  = r_count >= w_lim;
    assign o_stat.over_limit  = r_count > w_lim;

    // Key store has no reset; entries are only read while valid.
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_keys[w_free_slot] <= r_key;
        end
        if (i_cmd.load_in) begin
            r_func <= lkoc_pkg::t_func'(i_func);
            r_key  <= i_key[KEY_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_res.pad            <= '0;
            r_res.present        <= w_hit;
            r_res.live_hit       <= w_promote && w_hit_live;
            r_res.created        <= w_hit && !w_hit_live
                                    && (r_func == lkoc_pkg::FUNC_GET);
            r_res.slot           <= w_hit_slot;
            r_res.evicted_count  <= '0;
            r_res.evicted_in_use <= '0;
            r_res.occupancy      <= r_count;
        end else if (i_cmd.insert) begin
            r_res.pad            <= '0;
            r_res.present        <= 1'b0;
            r_res.live_hit       <= 1'b0;
            r_res.created        <= 1'b1;
            r_res.slot           <= w_free_slot;
            r_res.evicted_count  <= r_ev_cnt;
            r_res.evicted_in_use <= r_ev_live;
            r_res.occupancy      <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_live    <= '0;
            r_count   <= '0;
            r_limit   <= CW'(lkoc_pkg::CAP_RESET);
            r_ev_cnt  <= '0;
            r_ev_live <= '0;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.apply) begin
                unique case (r_func)
                    lkoc_pkg::FUNC_GET: begin
                        if (w_hit) begin
                            r_live[w_hit_slot] <= 1'b1;
                        end
                    end
                    lkoc_pkg::FUNC_RELEASE: begin
                        if (w_hit) begin
                            r_live[w_hit_slot] <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
                if (w_promote) begin
                    for (int i = 0; i < N; i++) begin
                        if (w_match[i]) begin
                            r_rank[i] <= '0;
                        end else if (r_valid[i] && r_rank[i] < w_hit_rank) begin
                            r_rank[i] <= r_rank[i] + IW'(1);
                        end
                    end
                end
            end
            if (i_cmd.clr_ev) begin
                r_ev_cnt  <= '0;
                r_ev_live <= '0;
            end
            // One least-recent entry leaves per cycle: the one ranked count-1.
            if (i_cmd.evict) begin
                r_valid   <= r_valid & ~w_victim;
                r_live    <= r_live & ~w_victim;
                r_count   <= w_cnt_m1;
                r_ev_cnt  <= r_ev_cnt + CW'(1);
                r_ev_live <= r_ev_live + CW'(w_victim_live);
            end
            if (i_cmd.insert) begin
                for (int i = 0; i < N; i++) begin
                    if (IW'(i) == w_free_slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
                r_valid[w_free_slot] <= 1'b1;
                r_live[w_free_slot]  <= 1'b1;
                r_count              <= r_count + CW'(1);
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- hw/rtl/lkoc_ctrl.sv -----
// Controller of the keyed object cache: sequences accept, execute, eviction
// and insertion, and owns the result valid flag. Uses lkoc_pkg.
module lkoc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  lkoc_pkg::t_stat i_stat,
    output lkoc_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EVICT,
        S_INSERT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.miss_create) begin
                    o_cmd.clr_ev = 1'b1;
                    n_state      = i_stat.need_evict ? S_EVICT : S_INSERT;
                end else if (w_out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                if (!i_stat.over_limit) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                if (w_out_free) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.apply || o_cmd.insert) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/lru_keyed_object_cache_core.sv -----
// Top level of the keyed object cache: fully associative LRU table of key
// digests. Instantiates lkoc_ctrl and lkoc_dpath; uses lkoc_pkg.
//
//  Channel  Direction  Beat contents
//  s_axis   in         tuser: func[1:0]; tdata: key[63:0]
//  m_axis   out        tdata: present, live_hit, created, slot, evicted_count,
//                      evicted_in_use, occupancy, zero pad (lowest bit up)
//  cfg      in         i_cfg_wdata: capacity_limit, written when i_cfg_we
//
// A lookup, release or hit is captured in S_IDLE, then matched in S_EXEC
// against all entries at once, updating recency. An inserting get-or-create
// goes to S_INSERT, first through S_EVICT at the limit, where the eviction
// unit removes one least-recent entry per cycle. Reset is synchronous and
// empties the table. A finished result waits in the output register while the
// next beat is accepted; a full, stalled output register holds the controller.
module lru_keyed_object_cache_core #(
    parameter int unsigned KEY_BITS = lkoc_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lkoc_pkg::KEY_W-1:0]    s_axis_tdata,  // key
    input  logic [lkoc_pkg::FUNC_W-1:0]   s_axis_tuser,  // func
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // present, live_hit, created, slot[3:0], evicted_count[4:0],
    // evicted_in_use[4:0], occupancy[4:0], two zero bits
    output logic [lkoc_pkg::RES_W-1:0]    m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [lkoc_pkg::CNT_W-1:0]    i_cfg_wdata
);

    lkoc_pkg::t_cmd  w_cmd;
    lkoc_pkg::t_stat w_stat;
    lkoc_pkg::t_res  w_res;

    lkoc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lkoc_dpath #(
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_func      (s_axis_tuser),
        .i_key       (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (w_res)
    );

    assign m_axis_tdata = w_res;

    // The table never reports more entries than it has.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_res.occupancy <= lkoc_pkg::CNT_W'(lkoc_pkg::ENTRIES))
        else $error("occupancy above table size");

    a_ev_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_res.evicted_in_use <= w_res.evicted_count)
        else $error("more live evictees than evictions");

    a_hit_xor_create: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(w_res.live_hit && w_res.created))
        else $error("live hit and creation in one result");

    // Only one operation is in flight at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("beat accepted while an operation is in progress");

    a_evict_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.insert |-> !w_stat.need_evict)
        else $error("insertion while table is at its limit");

endmodule
